// ===== src/mcc_pkg.sv =====
// Shared types, character constants and letter code tables for the Morse codec.
// Used by every module of the codec; depends on nothing else.
package mcc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_SYMBOLS = 4;
  localparam int LETTER_COUNT = 26;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // One queued job: either a Morse sequence (symbols then a space) or one byte.
  typedef struct packed {
    logic       morse;
    logic [2:0] len;
    logic [3:0] pat;
    logic [7:0] ch;
  } job_t;

  // Code of a letter by index: {length, pattern}, symbol k in bit k, 1 = dash.
  function automatic logic [6:0] letter_code(input logic [4:0] idx);
    logic [6:0] code;
    begin
      case (idx)
        5'd0: code = {3'd2, 4'b0010};
        5'd1: code = {3'd4, 4'b0001};
        5'd2: code = {3'd4, 4'b0101};
        5'd3: code = {3'd3, 4'b0001};
        5'd4: code = {3'd1, 4'b0000};
        5'd5: code = {3'd4, 4'b0100};
        5'd6: code = {3'd3, 4'b0011};
        5'd7: code = {3'd4, 4'b0000};
        5'd8: code = {3'd2, 4'b0000};
        5'd9: code = {3'd4, 4'b1110};
        5'd10: code = {3'd3, 4'b0101};
        5'd11: code = {3'd4, 4'b0010};
        5'd12: code = {3'd2, 4'b0011};
        5'd13: code = {3'd2, 4'b0001};
        5'd14: code = {3'd3, 4'b0111};
        5'd15: code = {3'd4, 4'b0110};
        5'd16: code = {3'd4, 4'b1011};
        5'd17: code = {3'd3, 4'b0010};
        5'd18: code = {3'd3, 4'b0000};
        5'd19: code = {3'd1, 4'b0001};
        5'd20: code = {3'd3, 4'b0100};
        5'd21: code = {3'd4, 4'b1000};
        5'd22: code = {3'd3, 4'b0110};
        5'd23: code = {3'd4, 4'b1001};
        5'd24: code = {3'd4, 4'b1101};
        5'd25: code = {3'd4, 4'b0011};
        default: code = 7'd0;
      endcase
      return code;
    end
  endfunction

  // Reverse lookup: {found, letter index} for a gathered code.
  function automatic logic [5:0] decode_letter(input logic [2:0] len, input logic [3:0] pat);
    logic [5:0] res;
    begin
      res = 6'd0;
      for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
        if (letter_code(5'(i)) == {len, pat}) begin
          res = {1'b1, 5'(i)};
        end
      end
      return res;
    end
  endfunction

endpackage

// ===== src/mcc_front.sv =====
// Front end of the Morse codec: accepts items, holds the pending decode code
// and turns each item into at most one job for the queue. Depends on mcc_pkg.
module mcc_front
  import mcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] char_in,
  input  logic       end_of_text,
  input  logic       queue_full,
  output logic       push,
  output job_t       push_job
);

  logic [3:0] code_pattern, code_pattern_next;
  logic [2:0] code_length, code_length_next;
  logic       code_invalid, code_invalid_next;

  logic       accept;
  logic [7:0] upper;
  logic       is_letter;
  logic [4:0] letter_idx;
  logic [6:0] enc_code;
  logic       is_space;
  logic       is_sym;
  logic [3:0] g_pattern;
  logic [2:0] g_length;
  logic       g_invalid;
  logic       close;
  logic [5:0] lookup;

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;

  // Encode classification: fold lower case onto upper case.
  always_comb begin
    upper = char_in;
    if (char_in inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      upper = char_in - CASE_OFFSET;
    end
    is_letter = upper inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
    letter_idx = 5'(upper - CHAR_UPPER_A);
    enc_code = letter_code(letter_idx);
    is_space = (char_in == CHAR_SPACE);
    is_sym = (char_in == CHAR_DOT) || (char_in == CHAR_DASH);
  end

  // Decode: gather a non-space byte into the pending code, then decide on closing.
  always_comb begin
    g_pattern = code_pattern;
    g_length = code_length;
    g_invalid = code_invalid;
    if (!is_space) begin
      if (is_sym && (code_length < 3'(MAX_SYMBOLS))) begin
        if (char_in == CHAR_DASH) begin
          g_pattern = code_pattern | (4'd1 << code_length[1:0]);
        end
      end else begin
        g_invalid = 1'b1;
      end
      if (code_length != 3'd7) begin
        g_length = code_length + 3'd1;
      end
    end
    close = (is_space || end_of_text) && (g_length != 3'd0);
    lookup = decode_letter(g_length, g_pattern);
  end

  // Job generation and next decode state.
  always_comb begin
    push = 1'b0;
    push_job = '0;
    code_pattern_next = code_pattern;
    code_length_next = code_length;
    code_invalid_next = code_invalid;
    if (accept) begin
      if (operation == OP_ENCODE) begin
        if (is_letter) begin
          push = 1'b1;
          push_job.morse = 1'b1;
          push_job.len = enc_code[6:4];
          push_job.pat = enc_code[3:0];
          push_job.ch = CHAR_SPACE;
        end else if (is_space) begin
          push = 1'b1;
          push_job.ch = CHAR_SPACE;
        end
      end else begin
        if (close) begin
          push = lookup[5] && !g_invalid;
          push_job.ch = CHAR_UPPER_A + {3'd0, lookup[4:0]};
          code_pattern_next = '0;
          code_length_next = '0;
          code_invalid_next = 1'b0;
        end else begin
          code_pattern_next = g_pattern;
          code_length_next = g_length;
          code_invalid_next = g_invalid;
        end
      end
    end
  end

  // Pending code registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_pattern <= '0;
      code_length <= '0;
      code_invalid <= 1'b0;
    end else begin
      code_pattern <= code_pattern_next;
      code_length <= code_length_next;
      code_invalid <= code_invalid_next;
    end
  end

endmodule

// ===== src/mcc_queue.sv =====
// Short job queue between the front and back ends of the Morse codec.
// Depends on mcc_pkg for the job type.
module mcc_queue
  import mcc_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== src/mcc_back.sv =====
// Back end of the Morse codec: walks the head job into a registered output
// stage, one byte per cycle while that stage is free. Depends on mcc_pkg.
module mcc_back
  import mcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out,
  output logic       last_of_run
);

  logic [2:0] idx, idx_next;
  logic       load;
  logic [2:0] total;
  logic [7:0] next_char;
  logic       next_last;

  // Select the byte at the current position of the head job.
  always_comb begin
    total = head.morse ? head.len + 3'd1 : 3'd1;
    next_last = (idx == total - 3'd1);
    if (head.morse && (idx < head.len)) begin
      next_char = head.pat[idx[1:0]] ? CHAR_DASH : CHAR_DOT;
    end else begin
      next_char = head.ch;
    end
    load = !empty && (!out_valid || out_ready);
    pop = load && next_last;
    idx_next = idx;
    if (load) begin
      idx_next = next_last ? 3'd0 : idx + 3'd1;
    end
  end

  // Position counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      char_out <= next_char;
      last_of_run <= next_last;
    end
  end

endmodule

// ===== src/morse_code_codec.sv =====
// Top level of the Morse codec for the 26 letters.
// Instantiates mcc_front, mcc_queue and mcc_back; depends on mcc_pkg.
//
// Input channel (in_valid/in_ready): one byte per transfer with operation
// (0 encode, 1 decode) and end_of_text. Output channel (out_valid/out_ready):
// one byte per transfer, last_of_run marks the final byte caused by an item.
// Encode: a letter gives its dots and dashes and a space (2 to 5 bytes), a
// space gives one space, anything else gives nothing. Decode: dots and dashes
// gather; a space or end_of_text closes the code and a known code gives its
// capital letter.
// The front end accepts an item and places its job in a queue of
// QueueDepth entries; in_ready falls only while that queue is full. The back
// end emits one byte per cycle from the queue head while the receiver takes
// them; the first byte of an item passes through the queue entry and the
// output register, and an item gives 1 to 5 result bytes.
// The serializer sets the rate: one result byte per cycle with a ready receiver.
// A stalled receiver holds the output register; the queue then fills and
// stalls the input. Reset empties the queue and clears the pending code.
module morse_code_codec
  import mcc_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] char_in,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out,
  output logic       last_of_run
);

  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic empty;
  job_t head;

  mcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .char_in     (char_in),
    .end_of_text (end_of_text),
    .queue_full  (full),
    .push        (push),
    .push_job    (push_job)
  );

  mcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  mcc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_out    (char_out),
    .last_of_run (last_of_run)
  );

endmodule
